FILE: rtl/text_line_visualizer_stream_defines.svh
// assertion macros for the text line visualizer rtl
// no dependencies; included by the modules that carry checks
`ifndef TEXT_LINE_VISUALIZER_STREAM_DEFINES_SVH
`define TEXT_LINE_VISUALIZER_STREAM_DEFINES_SVH

// same-cycle implication, off during reset
`define TLVS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define TLVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tlvs_pkg.sv
// types, character codes and register indexes for the text line visualizer
// no dependencies; imported by every module of the block
`default_nettype none

package tlvs_pkg;

    localparam int NUM_DIGITS_DEF = 6;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int BODY_MAX       = 4;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUMBER_LINES     = 3'd0,
        REG_NUMBER_NONBLANK  = 3'd1,
        REG_SQUEEZE_BLANK    = 3'd2,
        REG_SHOW_ENDS        = 3'd3,
        REG_SHOW_TABS        = 3'd4,
        REG_SHOW_NONPRINTING = 3'd5
    } t_cfg_reg;

    // character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CTRL_MAX  = 8'h20;
    localparam logic [7:0] CARET_BIT = 8'h40;

    typedef struct packed {
        logic number_lines;
        logic number_nonblank;
        logic squeeze_blank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprinting;
    } t_cfg;

    // one classified item: optional number prefix plus up to four body bytes
    typedef struct packed {
        logic                       num;
        logic [2:0]                 body_len;
        logic [BODY_MAX-1:0][7:0]   body;
    } t_desc;

endpackage

`default_nettype wire

FILE: rtl/tlvs_front.sv
// front part: accepts input bytes, tracks line state and bcd line counter,
// classifies each byte into a descriptor; uses tlvs_pkg
`default_nettype none

module tlvs_front #(
    parameter int NUMBER_DIGITS = tlvs_pkg::NUM_DIGITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire tlvs_pkg::t_cfg               i_cfg,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [7:0]                   i_byte,
    input  wire logic                         i_file_start,
    input  wire logic                         i_full,
    output logic                              o_push,
    output tlvs_pkg::t_desc                   o_desc,
    output logic [4*NUMBER_DIGITS-1:0]        o_bcd,
    output logic [NUMBER_DIGITS-1:0]          o_lead
);
    import tlvs_pkg::*;

    localparam int BW = 4 * NUMBER_DIGITS;

    logic          r_after_nl, n_after_nl;
    logic          r_bsq, n_bsq;
    logic [BW-1:0] r_bcd, n_bcd;

    logic          accept, was_nl, is_nl, drop, do_num, bsq_base, all_nines, carry, zero_run;
    logic [BW-1:0] bcd_base, bcd_inc;
    logic [7:0]    low;
    logic [1:0]    k;

    // no item is taken while reset is held
    assign o_ready = i_rst_n && !i_full;
    assign accept  = i_valid && o_ready;
    assign is_nl   = (i_byte == CH_NL);

    // line state seen by this byte, after a possible file restart
    assign was_nl   = i_file_start || r_after_nl;
    assign bcd_base = i_file_start ? '0 : r_bcd;
    assign bsq_base = i_file_start ? 1'b0 : r_bsq;

    assign drop   = was_nl && i_cfg.squeeze_blank && is_nl && bsq_base;
    assign do_num = was_nl && !drop && i_cfg.number_lines
                    && (!i_cfg.number_nonblank || !is_nl);
    assign o_push = accept && !drop;

    // saturating bcd increment
    always_comb begin
        all_nines = 1'b1;
        carry     = 1'b1;
        bcd_inc   = bcd_base;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (bcd_base[4*i +: 4] != 4'd9) all_nines = 1'b0;
        end
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (carry) begin
                if (bcd_base[4*i +: 4] >= 4'd9) begin
                    bcd_inc[4*i +: 4] = 4'd0;
                end else begin
                    bcd_inc[4*i +: 4] = bcd_base[4*i +: 4] + 4'd1;
                    carry             = 1'b0;
                end
            end
        end
        if (all_nines) bcd_inc = bcd_base;
    end

    assign n_bcd      = do_num ? bcd_inc : bcd_base;
    assign n_after_nl = is_nl;
    assign n_bsq      = (was_nl && i_cfg.squeeze_blank) ? is_nl : bsq_base;

    // leading positions that print as spaces
    always_comb begin
        zero_run = 1'b1;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
            zero_run  = zero_run && (n_bcd[4*i +: 4] == 4'd0);
            o_lead[i] = zero_run && (i != 0);
        end
    end
    assign o_bcd = n_bcd;

    // body bytes of the item
    always_comb begin
        o_desc          = '0;
        o_desc.num      = do_num;
        o_desc.body[0]  = i_byte;
        o_desc.body_len = 3'd1;
        low             = {1'b0, i_byte[6:0]};
        k               = 2'd0;
        priority if (is_nl) begin
            if (i_cfg.show_ends) begin
                o_desc.body[0]  = CH_DOLLAR;
                o_desc.body[1]  = CH_NL;
                o_desc.body_len = 3'd2;
            end
        end else if (i_byte == CH_TAB) begin
            if (i_cfg.show_tabs) begin
                o_desc.body[0]  = CH_CARET;
                o_desc.body[1]  = CH_I;
                o_desc.body_len = 3'd2;
            end
        end else if (i_cfg.show_nonprinting) begin
            if (i_byte[7]) begin
                o_desc.body[0] = CH_M;
                o_desc.body[1] = CH_DASH;
                k              = 2'd2;
            end
            if (low < CTRL_MAX || low == CH_DEL) begin
                o_desc.body[k]      = CH_CARET;
                o_desc.body[k + 2'd1] = (low == CH_DEL) ? CH_QMARK : (low | CARET_BIT);
                o_desc.body_len     = {1'b0, k} + 3'd2;
            end else begin
                o_desc.body[k]  = low;
                o_desc.body_len = {1'b0, k} + 3'd1;
            end
        end else begin
            o_desc.body[0] = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_nl <= 1'b1;
            r_bsq      <= 1'b0;
            r_bcd      <= '0;
        end else if (accept) begin
            r_after_nl <= n_after_nl;
            r_bsq      <= n_bsq;
            r_bcd      <= n_bcd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tlvs_queue.sv
// short descriptor queue between front and back parts
// register based fifo; uses tlvs_pkg for its depth
`default_nettype none

module tlvs_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_full,
    output logic                  o_empty
);
    import tlvs_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tlvs_back.sv
// back part: walks each descriptor byte by byte into the output register
// uses tlvs_pkg and the assertion macro header
`default_nettype none
`include "text_line_visualizer_stream_defines.svh"

module tlvs_back #(
    parameter int NUMBER_DIGITS = tlvs_pkg::NUM_DIGITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_head_valid,
    input  wire tlvs_pkg::t_desc              i_desc,
    input  wire logic [4*NUMBER_DIGITS-1:0]   i_bcd,
    input  wire logic [NUMBER_DIGITS-1:0]     i_lead,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [7:0]                        o_byte,
    output logic                              o_last
);
    import tlvs_pkg::*;

    localparam int IW = $clog2(NUMBER_DIGITS + 6);
    localparam int DW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

    logic [IW-1:0] r_idx, n_idx;
    logic          r_out_valid;
    logic [7:0]    r_out_byte, n_byte;
    logic          r_out_last;

    logic [IW-1:0] num_pre, total, body_off, dpos;
    logic [DW-1:0] dsel;
    logic [1:0]    bsel;
    logic [3:0]    dig [NUMBER_DIGITS];
    logic          produce, last;

    always_comb begin
        for (int i = 0; i < NUMBER_DIGITS; i++) dig[i] = i_bcd[4*i +: 4];
    end

    assign num_pre  = i_desc.num ? IW'(NUMBER_DIGITS + 1) : '0;
    assign total    = num_pre + IW'(i_desc.body_len);
    assign last     = (r_idx == total - 1'b1);
    assign produce  = i_head_valid && (!r_out_valid || i_ready);
    assign o_pop    = produce && last;
    assign n_idx    = o_pop ? '0 : r_idx + 1'b1;

    // digits go out most significant first
    assign dpos     = IW'(NUMBER_DIGITS - 1) - r_idx;
    assign dsel     = dpos[DW-1:0];
    assign body_off = r_idx - num_pre;
    assign bsel     = body_off[1:0];

    always_comb begin
        priority if (i_desc.num && r_idx < IW'(NUMBER_DIGITS)) begin
            n_byte = i_lead[dsel] ? CH_SPACE : (CH_ZERO | {4'd0, dig[dsel]});
        end else if (i_desc.num && r_idx == IW'(NUMBER_DIGITS)) begin
            n_byte = CH_TAB;
        end else begin
            n_byte = i_desc.body[bsel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (produce) r_idx <= n_idx;
            if (produce)      r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_out_byte <= n_byte;
            r_out_last <= last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

    `TLVS_ASSERT_IMPL(a_idx_in_range, i_clk, i_rst_n,
        i_head_valid, r_idx < total, "step index past end of item")
    `TLVS_ASSERT_IMPL(a_mid_item_held, i_clk, i_rst_n,
        r_idx != '0, i_head_valid, "item left queue mid expansion")
    `TLVS_ASSERT_NEXT(a_last_marked, i_clk, i_rst_n,
        o_pop, r_out_valid && r_out_last, "final byte not marked")

endmodule

`default_nettype wire

FILE: rtl/text_line_visualizer_stream.sv
// top level of the text line visualizer: config registers, front, queue, back
// depends on tlvs_pkg, tlvs_front, tlvs_queue, tlvs_back
//
//   channel  dir  handshake                     payload
//   s_axis   in   s_axis_tvalid/s_axis_tready   tdata: data_byte; tuser: file_start
//   m_axis   out  m_axis_tvalid/m_axis_tready   tdata: out_byte;  tlast: last_of_run
//   cfg      in   i_cfg_we (no handshake back)  i_cfg_index, i_cfg_data
//
// each input byte becomes 0 to NUMBER_DIGITS+5 output bytes, one per cycle while
// m_axis_tready allows, counted out by the back part's step index
// plain bytes pass at one item per cycle while nothing stalls; the first byte of
// an item passes queue and output register; a squeezed blank line produces nothing
// outside reset, the front stalls only when the two-entry descriptor queue is full
// reset is synchronous, active low; s_axis_tready is low during reset
`default_nettype none

module text_line_visualizer_stream #(
    parameter int NUMBER_DIGITS = tlvs_pkg::NUM_DIGITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [tlvs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [0:0]                      i_cfg_data,
    // input stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
    input  wire logic [0:0]                      s_axis_tuser,  // [0] file_start
    // output stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [7:0]                           m_axis_tdata,  // [7:0] out_byte
    output logic                                 m_axis_tlast   // last_of_run
);
    import tlvs_pkg::*;

    localparam int BW = 4 * NUMBER_DIGITS;
    localparam int QW = BW + NUMBER_DIGITS + $bits(t_desc);

    t_cfg                     r_cfg;
    logic                     push, pop, q_full, q_empty;
    t_desc                    f_desc, h_desc;
    logic [BW-1:0]            f_bcd, h_bcd;
    logic [NUMBER_DIGITS-1:0] f_lead, h_lead;
    logic [QW-1:0]            q_wdata, q_rdata;

    // config registers, writes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_NUMBER_LINES:     r_cfg.number_lines     <= i_cfg_data[0];
                REG_NUMBER_NONBLANK:  r_cfg.number_nonblank  <= i_cfg_data[0];
                REG_SQUEEZE_BLANK:    r_cfg.squeeze_blank    <= i_cfg_data[0];
                REG_SHOW_ENDS:        r_cfg.show_ends        <= i_cfg_data[0];
                REG_SHOW_TABS:        r_cfg.show_tabs        <= i_cfg_data[0];
                REG_SHOW_NONPRINTING: r_cfg.show_nonprinting <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // classify bytes and keep line state
    tlvs_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_byte       (s_axis_tdata),
        .i_file_start (s_axis_tuser[0]),
        .i_full       (q_full),
        .o_push       (push),
        .o_desc       (f_desc),
        .o_bcd        (f_bcd),
        .o_lead       (f_lead)
    );

    assign q_wdata = {f_bcd, f_lead, f_desc};

    // descriptor queue decouples input stalls from output stalls
    tlvs_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (q_wdata),
        .i_pop   (pop),
        .o_rdata (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign {h_bcd, h_lead, h_desc} = q_rdata;

    // expand descriptors into output bytes
    tlvs_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!q_empty),
        .i_desc       (h_desc),
        .i_bcd        (h_bcd),
        .i_lead       (h_lead),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (m_axis_tdata),
        .o_last       (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// self-checking bench for text_line_visualizer_stream: byte stream in, rendered text out
// depends on tlvs_pkg and the rtl of the block; carries its own line-rendering predictor
`timescale 1ns / 100ps

module tb_top;
    import tlvs_pkg::*;

    localparam int NDIG         = NUM_DIGITS_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int IDLE_PCT     = 25;
    localparam int PHASE_ITEMS  = 45;

    // indexes past the last register, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [4*NDIG-1:0] BCD_FULL = {NDIG{4'h9}};

    // one input item: raw byte plus new-file flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } t_text_item;

    // one rendered output item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_rendered;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [0:0]           i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;   // [7:0] data_byte
    logic [0:0]           s_axis_tuser = '0;   // [0] file_start
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;        // [7:0] out_byte
    logic                 m_axis_tlast;        // last_of_run

    text_line_visualizer_stream uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // stimulus waiting to go out, and rendered bytes waiting to come back
    t_text_item pending_items[$];
    t_rendered  rendered_q[$];

    // predictor copy of the options and the line state
    t_cfg              opts = '0;
    logic              at_line_start = 1'b1;
    logic              blank_done = 1'b0;
    logic [4*NDIG-1:0] line_bcd = '0;

    logic item_taken = 1'b0;
    logic quiet_stretch = 1'b0;     // no idling on either side while set
    int   mismatch_count = 0;
    int   items_sent = 0;
    int   results_seen = 0;
    int   settings_done = 0;
    int   cycle_count = 0;

    // render one raw byte the way the block should, queue the bytes it yields
    task automatic render_byte(input logic [7:0] raw, input logic new_file);
        logic [7:0] ch;
        logic       line_start;
        logic       lead;
        logic       carry;
        logic [3:0] dig;
        logic [7:0] outs[$];
        ch = raw;
        line_start = at_line_start;
        if (new_file) begin
            line_bcd = '0;
            blank_done = 1'b0;
            line_start = 1'b1;
        end
        at_line_start = (ch == CH_NL);

        if (line_start) begin
            // squeeze: second and later empty lines of a run vanish
            if (opts.squeeze_blank) begin
                if (ch == CH_NL) begin
                    if (blank_done)
                        return;
                    blank_done = 1'b1;
                end else begin
                    blank_done = 1'b0;
                end
            end
            if (opts.number_lines && (!opts.number_nonblank || ch != CH_NL)) begin
                // bcd count, sticks at all nines
                if (line_bcd != BCD_FULL) begin
                    carry = 1'b1;
                    for (int i = 0; i < NDIG; i++) begin
                        if (carry) begin
                            if (line_bcd[4*i +: 4] >= 4'd9) begin
                                line_bcd[4*i +: 4] = 4'd0;
                            end else begin
                                line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
                                carry = 1'b0;
                            end
                        end
                    end
                end
                // right aligned, leading zeros as spaces, lowest digit always shown
                lead = 1'b1;
                for (int i = NDIG - 1; i >= 0; i--) begin
                    dig = line_bcd[4*i +: 4];
                    if (dig != 4'd0 || i == 0)
                        lead = 1'b0;
                    outs.push_back(lead ? CH_SPACE : CH_ZERO + {4'h0, dig});
                end
                outs.push_back(CH_TAB);
            end
        end

        if (ch == CH_NL) begin
            if (opts.show_ends)
                outs.push_back(CH_DOLLAR);
            outs.push_back(CH_NL);
        end else if (ch == CH_TAB) begin
            if (opts.show_tabs) begin
                outs.push_back(CH_CARET);
                outs.push_back(CH_I);
            end else begin
                outs.push_back(CH_TAB);
            end
        end else if (opts.show_nonprinting) begin
            // high half first gets M- and drops bit 7, then control forms
            if (ch[7]) begin
                outs.push_back(CH_M);
                outs.push_back(CH_DASH);
                ch[7] = 1'b0;
            end
            if (ch < CTRL_MAX || ch == CH_DEL) begin
                outs.push_back(CH_CARET);
                outs.push_back(ch == CH_DEL ? CH_QMARK : (ch | CARET_BIT));
            end else begin
                outs.push_back(ch);
            end
        end else begin
            outs.push_back(ch);
        end

        foreach (outs[k])
            rendered_q.push_back('{out_byte: outs[k], last_of_run: (k == outs.size() - 1)});
    endtask

    // input side: hold each item until taken, random gaps between items
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || item_taken) begin
            if (pending_items.size() != 0 &&
                (quiet_stretch || $urandom_range(99) >= IDLE_PCT)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_items[0].data_byte;
                s_axis_tuser  <= pending_items[0].file_start;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        item_taken = 1'b0;
    end

    // input handshake: predict the rendering of each accepted item
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            render_byte(s_axis_tdata, s_axis_tuser[0]);
            void'(pending_items.pop_front());
            item_taken = 1'b1;
            items_sent++;
        end
    end

    // output side backpressure
    always @(negedge i_clk) begin
        m_axis_tready <= quiet_stretch || ($urandom_range(99) >= IDLE_PCT);
    end

    // output checker: every accepted item against the oldest prediction
    always @(posedge i_clk) begin : check_output
        t_rendered want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (rendered_q.size() == 0) begin
                $error("unexpected output item: out_byte=%h last_of_run=%b",
                       m_axis_tdata, m_axis_tlast);
                mismatch_count++;
            end else begin
                want = rendered_q.pop_front();
                if (m_axis_tdata !== want.out_byte) begin
                    $error("out_byte: expected %h, got %h", want.out_byte, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.last_of_run) begin
                    $error("last_of_run: expected %b, got %b",
                           want.last_of_run, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d output items still due",
                     cycle_count, rendered_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // one register write; the predictor takes the value at once since the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            REG_NUMBER_LINES:     opts.number_lines     = val;
            REG_NUMBER_NONBLANK:  opts.number_nonblank  = val;
            REG_SQUEEZE_BLANK:    opts.squeeze_blank    = val;
            REG_SHOW_ENDS:        opts.show_ends        = val;
            REG_SHOW_TABS:        opts.show_tabs        = val;
            REG_SHOW_NONPRINTING: opts.show_nonprinting = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_options(input t_cfg c);
        write_reg(REG_NUMBER_LINES,     c.number_lines);
        write_reg(REG_NUMBER_NONBLANK,  c.number_nonblank);
        write_reg(REG_SQUEEZE_BLANK,    c.squeeze_blank);
        write_reg(REG_SHOW_ENDS,        c.show_ends);
        write_reg(REG_SHOW_TABS,        c.show_tabs);
        write_reg(REG_SHOW_NONPRINTING, c.show_nonprinting);
        settings_done++;
    endtask

    // wait until everything sent has come back, then let squeezed items clear the pipe
    task automatic settle();
        while (pending_items.size() != 0 || s_axis_tvalid || rendered_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // text-like byte mix: newlines, tabs, any byte, printable ascii; rare new files
    function automatic t_text_item random_item(input int newline_pct);
        t_text_item it;
        int roll;
        roll = $urandom_range(99);
        it.file_start = ($urandom_range(149) == 0);
        if (roll < newline_pct)
            it.data_byte = CH_NL;
        else if (roll < newline_pct + 8)
            it.data_byte = CH_TAB;
        else if (roll < newline_pct + 30)
            it.data_byte = 8'($urandom_range(255));
        else
            it.data_byte = 8'($urandom_range(8'h7E, 8'h20));
        return it;
    endfunction

    initial begin
        t_cfg cfg;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset options: everything passes through unchanged
        pending_items.push_back('{8'h61, 1'b1});
        pending_items.push_back('{8'h00, 1'b0});
        pending_items.push_back('{8'hFF, 1'b0});
        pending_items.push_back('{CH_TAB, 1'b0});
        pending_items.push_back('{CH_NL, 1'b0});
        pending_items.push_back('{CH_DEL, 1'b0});
        settle();

        // every option on: squeezed blank run, caret and meta forms, numbering
        set_options(6'b111111);
        pending_items.push_back('{CH_NL, 1'b1});
        pending_items.push_back('{CH_NL, 1'b0});
        pending_items.push_back('{CH_NL, 1'b0});
        pending_items.push_back('{8'h78, 1'b0});
        pending_items.push_back('{CH_TAB, 1'b0});
        pending_items.push_back('{8'h00, 1'b0});
        pending_items.push_back('{8'h1F, 1'b0});
        pending_items.push_back('{CH_DEL, 1'b0});
        pending_items.push_back('{8'h80, 1'b0});
        pending_items.push_back('{8'h9B, 1'b0});
        pending_items.push_back('{8'hFF, 1'b0});
        pending_items.push_back('{8'hA0, 1'b0});
        pending_items.push_back('{CH_NL, 1'b0});
        settle();

        // numbering of non-empty lines only; writes past the last register ignored
        set_options(6'b110000);
        write_reg(REG_SPARE_LO, 1'b1);
        write_reg(REG_SPARE_HI, 1'b1);
        pending_items.push_back('{CH_NL, 1'b0});
        pending_items.push_back('{CH_NL, 1'b0});
        pending_items.push_back('{8'h62, 1'b0});
        pending_items.push_back('{CH_NL, 1'b0});
        settle();

        // random phases, both extremes first, one phase with no idling at all
        for (int p = 0; p < 6; p++) begin
            if (p == 0)
                cfg = 6'b111111;
            else if (p == 1)
                cfg = 6'b000000;
            else
                cfg = 6'($urandom_range(63));
            set_options(cfg);
            quiet_stretch = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_items.push_back(random_item(30));
            settle();
            quiet_stretch = 1'b0;
        end

        // many short lines so the line count runs through digit carries
        set_options(6'b100000);
        for (int n = 0; n < 50; n++)
            pending_items.push_back(random_item(70));
        settle();

        $display("%0d input items sent, %0d output items checked, %0d option settings",
                 items_sent, results_seen, settings_done);
        $display("covered squeezing, numbering, line-end, tab and caret/meta forms");
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
